// ===== hw/rtl/dq_pkg.sv =====
// Shared types and codes for the double-ended queue.
// Holds request, status and shift codes and the cell control struct.
// No dependencies.
package dq_pkg;

  localparam int DQ_REQ_W        = 3;
  localparam int DQ_STATUS_W     = 2;
  localparam int DQ_KEEP_W       = 5;
  localparam int DQ_COUNT_W      = 5;
  localparam int DQ_PORT_VALUE_W = 32;

  // Request codes
  localparam logic [DQ_REQ_W-1:0] DQ_REQ_QUERY      = 3'd0;
  localparam logic [DQ_REQ_W-1:0] DQ_REQ_PUSH_BACK  = 3'd1;
  localparam logic [DQ_REQ_W-1:0] DQ_REQ_PUSH_FRONT = 3'd2;
  localparam logic [DQ_REQ_W-1:0] DQ_REQ_POP_BACK   = 3'd3;
  localparam logic [DQ_REQ_W-1:0] DQ_REQ_POP_FRONT  = 3'd4;
  localparam logic [DQ_REQ_W-1:0] DQ_REQ_TRIM_FRONT = 3'd5;
  localparam logic [DQ_REQ_W-1:0] DQ_REQ_TRIM_BACK  = 3'd6;

  // Status codes
  localparam logic [DQ_STATUS_W-1:0] DQ_ST_OK         = 2'd0;
  localparam logic [DQ_STATUS_W-1:0] DQ_ST_POP_EMPTY  = 2'd1;
  localparam logic [DQ_STATUS_W-1:0] DQ_ST_PUSH_FULL  = 2'd2;

  // Shift direction along the cell row
  localparam logic [1:0] DQ_SH_HOLD  = 2'd0;
  localparam logic [1:0] DQ_SH_LEFT  = 2'd1; // toward the front: pop front, trim front
  localparam logic [1:0] DQ_SH_RIGHT = 2'd2; // away from the front: push front

  typedef struct packed {
    logic [1:0] shift;
    logic       add_back;
    logic       drop_back;
    logic       trim_back;
  } dq_ctrl_t;

endpackage

// ===== hw/rtl/dq_cell.sv =====
// One storage cell of the queue row: a value and a valid bit.
// Moves data to and from its neighbors under a broadcast control word.
// Depends on dq_pkg.
module dq_cell
  import dq_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int KW          = 5,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dq_ctrl_t               ctrl,
  input  logic [KW-1:0]          keep,
  input  logic [VALUE_WIDTH-1:0] din,
  input  logic [VALUE_WIDTH-1:0] prev_data,
  input  logic                   prev_valid,
  input  logic [VALUE_WIDTH-1:0] next_data,
  input  logic                   next_valid,
  output logic [VALUE_WIDTH-1:0] data_o,
  output logic                   valid_o,
  output logic [VALUE_WIDTH-1:0] tail_data_o
);

  logic [VALUE_WIDTH-1:0] data_r, data_nxt;
  logic                   valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    case (ctrl.shift)
      DQ_SH_RIGHT: begin
        data_nxt  = prev_data;
        valid_nxt = prev_valid;
      end
      DQ_SH_LEFT: begin
        data_nxt  = next_data;
        valid_nxt = next_valid;
      end
      default: begin
      end
    endcase
    // first empty cell takes the pushed value
    if (ctrl.add_back && !valid_r && prev_valid) begin
      data_nxt  = din;
      valid_nxt = 1'b1;
    end
    // last held cell drops out
    if (ctrl.drop_back && valid_r && !next_valid) begin
      valid_nxt = 1'b0;
    end
    if (ctrl.trim_back && (KW'(IDX) >= keep)) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign data_o      = data_r;
  assign valid_o     = valid_r;
  assign tail_data_o = (valid_r && !next_valid) ? data_r : '0;

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue built as a row of shifting storage cells.
// Depends on dq_pkg and dq_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   query, push back, push front, pop back, pop front, trim front, trim back.
//   Output channel (out_valid / out_stall) returns one result per request:
//   status, front and back values, entry count and an empty flag.
//   Cell 0 always holds the front entry; held entries occupy a contiguous run
//   of cells from cell 0, so the back entry is the last valid cell.
// Request flow:
//   A request updates the cells, count and status; its result is then
//   registered once the result register is free. Requests are taken one per
//   cycle unless a stalled result or a trim front in progress holds them; a trim front
//   dropping N entries shifts the row one cell per cycle, then registers its
//   result. The back value comes from an OR tree over all CAPACITY cells.
// Reset (rst_n low, synchronous): all cells read empty, count is zero, no
//   result is pending. Stored values are not cleared.
// Receiver stall: the result register holds while out_stall is high; one
//   further request may be taken, and then in_stall rises until the result
//   register drains.
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [DQ_REQ_W-1:0]        in_req_type,
  input  logic [DQ_PORT_VALUE_W-1:0] in_value,
  input  logic [DQ_KEEP_W-1:0]       in_keep_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [DQ_STATUS_W-1:0]     out_status,
  output logic [DQ_PORT_VALUE_W-1:0] out_front_value,
  output logic [DQ_PORT_VALUE_W-1:0] out_back_value,
  output logic [DQ_COUNT_W-1:0]      out_count,
  output logic                       out_is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (CW > DQ_KEEP_W) ? CW : DQ_KEEP_W;

  // control state
  logic [CW-1:0]          count_r, count_nxt;
  logic [CW-1:0]          trim_left_r, trim_left_nxt;
  logic                   rep_r, rep_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [DQ_STATUS_W-1:0] status_r, status_nxt;

  // result register
  logic [DQ_STATUS_W-1:0]     out_status_r;
  logic [DQ_PORT_VALUE_W-1:0] out_front_r, out_back_r;
  logic [DQ_COUNT_W-1:0]      out_count_r;
  logic                       out_empty_r;

  logic in_xfer, out_free, report_fire;
  logic full, empty;
  logic [KW-1:0] keep_w, count_w;
  logic [CW-1:0] excess;
  dq_ctrl_t      ctrl;

  logic [VALUE_WIDTH-1:0] din;
  logic [VALUE_WIDTH-1:0] chain_data  [CAPACITY+2];
  logic                   chain_valid [CAPACITY+2];
  logic [VALUE_WIDTH-1:0] tail_data   [CAPACITY];
  logic [VALUE_WIDTH-1:0] front_sel, back_sel;

  assign out_free    = !out_valid_r || !out_stall;
  assign report_fire = rep_r && (trim_left_r == '0) && out_free;
  assign in_stall    = !((trim_left_r == '0) && (!rep_r || report_fire));
  assign in_xfer     = in_valid && !in_stall;

  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);
  assign keep_w  = KW'(in_keep_count);
  assign count_w = KW'(count_r);
  assign excess  = CW'(count_w - keep_w);
  assign din     = VALUE_WIDTH'(in_value);

  // Decode the request into a cell control word, the new count and status, or continue a trim front.
  always_comb begin
    ctrl          = '0;
    count_nxt     = count_r;
    trim_left_nxt = trim_left_r;
    status_nxt    = status_r;
    rep_nxt       = rep_r;
    if (report_fire) begin
      rep_nxt = 1'b0;
    end
    if (trim_left_r != '0) begin
      // continue a trim front: advance the row by one cell
      ctrl.shift    = DQ_SH_LEFT;
      trim_left_nxt = trim_left_r - 1'b1;
    end else if (in_xfer) begin
      rep_nxt    = 1'b1;
      status_nxt = DQ_ST_OK;
      case (in_req_type)
        DQ_REQ_PUSH_BACK: begin
          if (full) begin
            status_nxt = DQ_ST_PUSH_FULL;
          end else begin
            ctrl.add_back = 1'b1;
            count_nxt     = count_r + 1'b1;
          end
        end
        DQ_REQ_PUSH_FRONT: begin
          if (full) begin
            status_nxt = DQ_ST_PUSH_FULL;
          end else begin
            ctrl.shift = DQ_SH_RIGHT;
            count_nxt  = count_r + 1'b1;
          end
        end
        DQ_REQ_POP_BACK: begin
          if (empty) begin
            status_nxt = DQ_ST_POP_EMPTY;
          end else begin
            ctrl.drop_back = 1'b1;
            count_nxt      = count_r - 1'b1;
          end
        end
        DQ_REQ_POP_FRONT: begin
          if (empty) begin
            status_nxt = DQ_ST_POP_EMPTY;
          end else begin
            ctrl.shift = DQ_SH_LEFT;
            count_nxt  = count_r - 1'b1;
          end
        end
        DQ_REQ_TRIM_FRONT: begin
          if (keep_w < count_w) begin
            ctrl.shift    = DQ_SH_LEFT;
            count_nxt     = CW'(keep_w);
            trim_left_nxt = excess - 1'b1;
          end
        end
        DQ_REQ_TRIM_BACK: begin
          if (keep_w < count_w) begin
            ctrl.trim_back = 1'b1;
            count_nxt      = CW'(keep_w);
          end
        end
        default: begin
          // query and the unused code change nothing
        end
      endcase
    end
  end

  // Cell row, with the pushed value tied in front of cell 0 and an empty
  // slot behind the last cell.
  assign chain_data[0]           = din;
  assign chain_valid[0]          = 1'b1;
  assign chain_data[CAPACITY+1]  = '0;
  assign chain_valid[CAPACITY+1] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .KW         (KW),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .keep       (keep_w),
      .din        (din),
      .prev_data  (chain_data[i]),
      .prev_valid (chain_valid[i]),
      .next_data  (chain_data[i+2]),
      .next_valid (chain_valid[i+2]),
      .data_o     (chain_data[i+1]),
      .valid_o    (chain_valid[i+1]),
      .tail_data_o(tail_data[i])
    );
  end

  // Front is cell 0; back is the one cell that flags itself as the tail.
  assign front_sel = chain_valid[1] ? chain_data[1] : '0;

  always_comb begin
    back_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_sel = back_sel | tail_data[i];
    end
  end

  assign out_valid_nxt = report_fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      trim_left_r <= '0;
      rep_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      trim_left_r <= trim_left_nxt;
      rep_r       <= rep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (report_fire) begin
      out_status_r <= status_r;
      out_front_r  <= DQ_PORT_VALUE_W'(front_sel);
      out_back_r   <= DQ_PORT_VALUE_W'(back_sel);
      out_count_r  <= DQ_COUNT_W'(count_r);
      out_empty_r  <= empty;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_count       = out_count_r;
  assign out_is_empty    = out_empty_r;

endmodule

// ===== hw/rtl/dq_checker.sv =====
// Port-level checks for the double-ended queue result channel.
// Depends on dq_pkg; bound to double_ended_queue below.
module dq_checker
  import dq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [DQ_STATUS_W-1:0]     out_status,
  input logic [DQ_PORT_VALUE_W-1:0] out_front_value,
  input logic [DQ_PORT_VALUE_W-1:0] out_back_value,
  input logic [DQ_COUNT_W-1:0]      out_count,
  input logic                       out_is_empty
);

  localparam logic [DQ_COUNT_W-1:0] FULL_COUNT = DQ_COUNT_W'(CAPACITY);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_count) && $stable(out_status))
    else $error("result changed while stalled");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> (out_front_value == '0) && (out_back_value == '0)
      && (out_count == '0))
    else $error("empty result carries values");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == DQ_ST_POP_EMPTY) |-> out_is_empty)
    else $error("pop error reported on a non-empty queue");

  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == DQ_ST_PUSH_FULL) |-> (out_count == FULL_COUNT)
      && !out_is_empty)
    else $error("push-full error reported below capacity");

endmodule

bind double_ended_queue dq_checker #(
  .CAPACITY(CAPACITY)
) u_dq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_front_value(out_front_value),
  .out_back_value (out_back_value),
  .out_count      (out_count),
  .out_is_empty   (out_is_empty)
);
